FILE: src/tst_pkg.sv
// touch slot tracker package: request, response, control and status types
// no dependencies; imported by every module of the tracker
`timescale 1ns / 1ps

package tst_pkg;

   // default number of contact slots
   localparam int SLOTS_DEF = 8;

   // event kinds; moved and the unused code share the search path
   localparam logic [1:0] CMD_BEGAN = 2'd0;
   localparam logic [1:0] CMD_ENDED = 2'd2;

   // one touch event request
   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        contact_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } tst_req_type;

   // one response per request
   typedef struct packed {
      logic               accepted;
      logic               matched;
      logic [2:0]         slot_index;
      logic [3:0]         active_count;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
   } tst_rsp_type;

   // controller commands to the datapath
   typedef struct packed {
      logic load;
      logic reject;
      logic alloc;
      logic match;
      logic step;
      logic swap_a;
      logic swap_b;
      logic emit;
   } tst_ctl_type;

   // datapath status to the controller
   typedef struct packed {
      logic is_began;
      logic is_ended;
      logic full;
      logic empty;
      logic id_hit;
      logic at_last;
   } tst_sts_type;

endpackage

FILE: src/touch_slot_tracker_unit.sv
// touch slot tracker top level: controller plus datapath
// a began request, or any request while no slot is active, goes from capture through DISPATCH
// and FINISH to the registered response strobe; a search visits one active slot per cycle,
// and a matched ended request then passes SWAP_LAST and SWAP_DONE; one request at a time:
// a new request is taken in the cycle the response strobe shows; the receiver cannot stall
// synchronous reset empties all slots and restores the identity order list
`timescale 1ns / 1ps

module touch_slot_tracker_unit #(
   parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tst_pkg::tst_req_type req_item,
   output logic                 rsp_valid,
   output tst_pkg::tst_rsp_type rsp_item
);
   import tst_pkg::*;

   tst_ctl_type ctl;
   tst_sts_type sts;

   // sequencing
   tst_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   // slot state and response register
   tst_datapath #(
      .SLOTS (SLOTS)
   ) u_data (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: src/tst_datapath.sv
// touch slot tracker datapath: order list, slot tables, search pointer, response register
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_datapath #(
   parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tst_pkg::tst_req_type req_item,
   input  tst_pkg::tst_ctl_type ctl,
   output tst_pkg::tst_sts_type sts,
   output logic                 rsp_valid,
   output tst_pkg::tst_rsp_type rsp_item
);
   import tst_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   tst_req_type        req_ff;
   logic [SW-1:0]      order_ff [SLOTS];
   logic [CW-1:0]      count_ff;
   logic [SW-1:0]      pos_ff;
   logic [SW-1:0]      slot_ff;
   logic               hit_ff;
   logic               acc_ff;
   logic [31:0]        id_ff [SLOTS];
   logic signed [15:0] x_ff [SLOTS];
   logic signed [15:0] y_ff [SLOTS];
   logic               rsp_valid_ff;
   tst_rsp_type        rsp_ff;
   tst_rsp_type        rsp_in;

   logic [CW-1:0] last;
   logic [SW-1:0] rd_addr;
   logic [SW-1:0] order_rd;
   logic [31:0]   slot_wide;
   logic [31:0]   count_wide;

   // single read port on the order list
   assign last     = count_ff - CW'(1);
   assign rd_addr  = ctl.alloc  ? count_ff[SW-1:0] :
                     ctl.swap_a ? last[SW-1:0] : pos_ff;
   assign order_rd = order_ff[rd_addr];

   // status back to the controller
   assign sts.is_began = (req_ff.cmd == CMD_BEGAN);
   assign sts.is_ended = (req_ff.cmd == CMD_ENDED);
   assign sts.full     = (count_ff == CW'(SLOTS));
   assign sts.empty    = (count_ff == '0);
   assign sts.id_hit   = (id_ff[order_rd] == req_ff.contact_id);
   assign sts.at_last  = (CW'(pos_ff) == last);

   // control state: order list, active count and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            order_ff[i] <= SW'(i);
         end
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit;
         if (ctl.alloc) begin
            count_ff <= count_ff + CW'(1);
         end
         if (ctl.swap_a) begin
            order_ff[pos_ff] <= order_rd;
         end
         if (ctl.swap_b) begin
            order_ff[last[SW-1:0]] <= slot_ff;
            count_ff               <= last;
         end
      end
   end

   // request capture, search pointer, match and accept flags, slot tables, response register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_item;
         pos_ff <= '0;
         hit_ff <= 1'b0;
         acc_ff <= 1'b1;
      end
      if (ctl.reject) begin
         acc_ff <= 1'b0;
      end
      if (ctl.step) begin
         pos_ff <= pos_ff + SW'(1);
      end
      if (ctl.alloc || ctl.match) begin
         slot_ff <= order_rd;
         hit_ff  <= 1'b1;
      end
      if (ctl.alloc) begin
         id_ff[order_rd] <= req_ff.contact_id;
         x_ff[order_rd]  <= req_ff.pos_x;
         y_ff[order_rd]  <= req_ff.pos_y;
      end
      if (ctl.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // response fields, masked to their widths
   assign slot_wide  = 32'(slot_ff);
   assign count_wide = 32'(count_ff);

   always_comb begin
      rsp_in.accepted     = acc_ff;
      rsp_in.matched      = hit_ff;
      rsp_in.slot_index   = hit_ff ? slot_wide[2:0] : 3'd0;
      rsp_in.active_count = count_wide[3:0];
      rsp_in.start_x      = hit_ff ? x_ff[slot_ff] : 16'sd0;
      rsp_in.start_y      = hit_ff ? y_ff[slot_ff] : 16'sd0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: src/tst_controller.sv
// touch slot tracker controller: sequences allocation, search, swap and response
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tst_pkg::tst_sts_type sts,
   output tst_pkg::tst_ctl_type ctl,
   output logic                 busy
);
   import tst_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DISPATCH,
      SEARCH,
      SWAP_LAST,
      SWAP_DONE,
      FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   // next state and commands
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            if (sts.is_began) begin
               if (sts.full) begin
                  ctl.reject = 1'b1;
               end else begin
                  ctl.alloc = 1'b1;
               end
               state_in = FINISH;
            end else if (sts.empty) begin
               state_in = FINISH;
            end else begin
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            if (sts.id_hit) begin
               ctl.match = 1'b1;
               state_in  = sts.is_ended ? SWAP_LAST : FINISH;
            end else if (sts.at_last) begin
               state_in = FINISH;
            end else begin
               ctl.step = 1'b1;
            end
         end
         SWAP_LAST: begin
            ctl.swap_a = 1'b1;
            state_in   = SWAP_DONE;
         end
         SWAP_DONE: begin
            ctl.swap_b = 1'b1;
            state_in   = FINISH;
         end
         FINISH: begin
            ctl.emit = 1'b1;
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

FILE: src/tst_checker.sv
// touch slot tracker port checker and its bind to the top level
// depends on tst_pkg and touch_slot_tracker_unit
`timescale 1ns / 1ps

module tst_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input tst_pkg::tst_req_type req_item,
   input logic                 rsp_valid,
   input tst_pkg::tst_rsp_type rsp_item
);
   import tst_pkg::*;

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after accepting a request");

   // each response strobe is a single pulse, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // the block is free again while the response shows
   a_free_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while the response is shown");

   // a response without a slot carries zero slot fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.matched |->
         rsp_item.slot_index == 3'd0 && rsp_item.start_x == 16'sd0 &&
         rsp_item.start_y == 16'sd0)
      else $error("slot fields not zero on a miss");

   // a rejected request never reports a slot
   a_reject_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.accepted |-> !rsp_item.matched)
      else $error("rejected request reported a slot");

endmodule

bind touch_slot_tracker_unit tst_checker u_chk (.*);
